/* hw/rtl/amm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Audio matrix mixer package
// Shared item layout, fixed-point widths and codes for the mixer cells.
// ----------------------------------------------------------------------------
package amm_pkg;

  // Number of sample fields that exist on each side of the stream.
  localparam int FIELD_CH   = 4;
  localparam int SMP_W      = 16;
  localparam int GAIN_W     = 16;
  localparam int IDX_W      = 2;
  localparam int PROD_W     = SMP_W + GAIN_W;
  // Gains are Q4.12, so the mix is brought back to Q1.15 by this shift.
  localparam int FRAC_SHIFT = 12;
  localparam int SAT_MAX    = 32767;
  localparam int SAT_MIN    = -32768;

  typedef enum logic {
    ACT_FRAME = 1'b0,
    ACT_GAIN  = 1'b1
  } action_e;

  typedef struct packed {
    action_e                                  action;
    logic [IDX_W-1:0]                         in_index;
    logic [IDX_W-1:0]                         out_index;
    logic signed [GAIN_W-1:0]                 gain;
    logic [FIELD_CH-1:0][SMP_W-1:0]           sample;
  } item_t;

endpackage
`default_nettype wire

/* hw/rtl/amm_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Mixer cell
// Holds the gains of one input column, adds its products to the passing sums.
// ----------------------------------------------------------------------------
module amm_cell #(
  parameter int CELL_IDX = 0,
  parameter int NUM_OUT  = 4,
  parameter int ACC_W    = 35
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           in_valid_i,
  input  amm_pkg::item_t                in_item_i,
  input  wire [NUM_OUT-1:0][ACC_W-1:0]  in_acc_i,
  output logic                          in_ready_o,
  output logic                          out_valid_o,
  output amm_pkg::item_t                out_item_o,
  output logic [NUM_OUT-1:0][ACC_W-1:0] out_acc_o,
  input  wire                           out_ready_i
);
  import amm_pkg::*;

  logic                          valid_q;
  item_t                         item_q;
  logic [NUM_OUT-1:0][ACC_W-1:0] acc_q, acc_d;
  logic [NUM_OUT-1:0][GAIN_W-1:0] gain_q;
  logic signed [SMP_W-1:0]       smp;
  logic                          take;
  logic                          col_hit;

  assign in_ready_o = !valid_q || out_ready_i;
  assign take       = in_valid_i && in_ready_o;
  assign col_hit    = (in_item_i.action == ACT_GAIN) &&
                      (int'(in_item_i.in_index) == CELL_IDX);

  // Columns beyond the sample fields see silence.
  generate
    if (CELL_IDX < FIELD_CH) begin : g_smp
      assign smp = $signed(in_item_i.sample[CELL_IDX]);
    end else begin : g_zero
      assign smp = '0;
    end
  endgenerate

  always_comb begin
    logic signed [PROD_W-1:0] prod;
    prod = '0;
    for (int r = 0; r < NUM_OUT; r++) begin
      prod     = smp * $signed(gain_q[r]);
      acc_d[r] = ACC_W'($signed(in_acc_i[r]) + prod);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      gain_q  <= '0;
    end else begin
      if (in_ready_o) begin
        valid_q <= in_valid_i;
      end
      for (int r = 0; r < NUM_OUT; r++) begin
        if (take && col_hit && (int'(in_item_i.out_index) == r)) begin
          gain_q[r] <= in_item_i.gain;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= in_item_i;
      acc_q  <= acc_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;
  assign out_acc_o   = acc_q;

  // A sample frame never disturbs the stored gains.
  a_frame_keeps_gain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && in_item_i.action == ACT_FRAME) |=> $stable(gain_q))
    else $error("gain changed by a sample frame");

  // Gains only change right after a gain write aimed at this column.
  a_gain_needs_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(gain_q) |-> $past(take && col_hit))
    else $error("gain changed without a write");

  // A held word is only released when the next stage takes it.
  a_drop_needs_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !out_ready_i) |=> valid_q)
    else $error("cell dropped a stalled word");

endmodule
`default_nettype wire

/* hw/rtl/amm_out.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Mixer output stage
// Scales the finished sums back to Q1.15, saturates and holds the frame.
// ----------------------------------------------------------------------------
module amm_out #(
  parameter int NUM_OUT = 4,
  parameter int ACC_W   = 35
) (
  input  wire                                           clk_i,
  input  wire                                           rst_ni,
  input  wire                                           in_valid_i,
  input  amm_pkg::item_t                                in_item_i,
  input  wire [NUM_OUT-1:0][ACC_W-1:0]                  in_acc_i,
  output logic                                          in_ready_o,
  output logic                                          out_valid_o,
  output logic [amm_pkg::FIELD_CH-1:0][amm_pkg::SMP_W-1:0] out_sample_o,
  input  wire                                           out_ready_i
);
  import amm_pkg::*;

  localparam int SH_W = ACC_W - FRAC_SHIFT;
  localparam logic signed [SH_W-1:0] HI = SH_W'(SAT_MAX);
  localparam logic signed [SH_W-1:0] LO = SH_W'(SAT_MIN);

  logic                              valid_q;
  logic [FIELD_CH-1:0][SMP_W-1:0]    smp_q, smp_d;
  logic                              is_frame;
  logic                              load;

  assign is_frame   = (in_item_i.action == ACT_FRAME);
  // Gain writes end here and never wait on the output register.
  assign in_ready_o = !valid_q || out_ready_i || !is_frame;
  assign load       = in_valid_i && in_ready_o && is_frame;

  always_comb begin
    logic signed [SH_W-1:0] sh;
    sh    = '0;
    smp_d = '0;
    for (int j = 0; j < FIELD_CH; j++) begin
      if (j < NUM_OUT) begin
        // Arithmetic shift gives rounding toward minus infinity.
        sh = SH_W'($signed(in_acc_i[j]) >>> FRAC_SHIFT);
        if (sh > HI) begin
          smp_d[j] = SMP_W'(SAT_MAX);
        end else if (sh < LO) begin
          smp_d[j] = SMP_W'(SAT_MIN);
        end else begin
          smp_d[j] = sh[SMP_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      smp_q <= smp_d;
    end
  end

  assign out_valid_o  = valid_q;
  assign out_sample_o = smp_q;

  // Every frame that reaches this stage becomes a result word.
  a_frame_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> valid_q)
    else $error("frame lost in output stage");

  // A gain write never produces a result word.
  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !is_frame && valid_q && !out_ready_i) |=> $stable(smp_q))
    else $error("gain write reached the output");

endmodule
`default_nettype wire

/* hw/rtl/audio_matrix_mixer_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Audio matrix mixer core
// Fixed-point matrix mixer: Q1.15 samples, Q4.12 gains, saturated Q1.15 mix.
// ----------------------------------------------------------------------------
// Unless the output stalls, the mixer takes one word per cycle and delivers
// one frame word per cycle in steady state. A word is either a gain write
// (tuser high), which stores one gain at an input column and output row and
// gives no result, or a sample frame (tuser low), which gives one output word
// holding for each output row the sum of every input sample times its gain,
// shifted right by 12, rounded toward minus infinity and saturated to 16 bits.
// The datapath is a row of NUM_IN cells, one per input column; each cell
// holds that column's gains and adds its products to the sums passing by.
// A frame passes NUM_IN + 1 registers, the NUM_IN cells and the output stage,
// before its result word is valid on the output. Words stay in order, so a
// gain write affects exactly the frames accepted after it. Gain writes to a
// row or column outside the configured counts are ignored. All gains are
// zero after reset. Stalls on the output side compress bubbles in the chain
// before the input stops taking words.
// ----------------------------------------------------------------------------
module audio_matrix_mixer_core #(
  parameter int NUM_IN  = 4,
  parameter int NUM_OUT = 4
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: in_index[1:0], out_index[3:2], gain[19:4], in_sample_0[35:20],
  //        in_sample_1[51:36], in_sample_2[67:52], in_sample_3[83:68], zero fill
  input  wire  [87:0] s_axis_tdata,
  // tuser: action[0] (0 = sample frame, 1 = gain write)
  input  wire  [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // tdata: out_sample_0[15:0], out_sample_1[31:16], out_sample_2[47:32],
  //        out_sample_3[63:48]
  output logic [63:0] m_axis_tdata
);
  import amm_pkg::*;

  // Wide enough to hold the exact sum of all products.
  localparam int ACC_W = PROD_W + 1 + $clog2(NUM_IN);

  logic                          valid_c [NUM_IN+1];
  logic                          ready_c [NUM_IN+1];
  item_t                         item_c  [NUM_IN+1];
  logic [NUM_OUT-1:0][ACC_W-1:0] acc_c   [NUM_IN+1];
  logic [FIELD_CH-1:0][SMP_W-1:0] out_smp;

  // Unpack the input word into the item layout.
  always_comb begin
    item_c[0].action    = action_e'(s_axis_tuser[0]);
    item_c[0].in_index  = s_axis_tdata[1:0];
    item_c[0].out_index = s_axis_tdata[3:2];
    item_c[0].gain      = $signed(s_axis_tdata[19:4]);
    for (int k = 0; k < FIELD_CH; k++) begin
      item_c[0].sample[k] = s_axis_tdata[20 + k*SMP_W +: SMP_W];
    end
  end

  assign valid_c[0]    = s_axis_tvalid;
  assign acc_c[0]      = '0;
  assign s_axis_tready = ready_c[0];

  generate
    for (genvar k = 0; k < NUM_IN; k++) begin : g_cell
      amm_cell #(
        .CELL_IDX (k),
        .NUM_OUT  (NUM_OUT),
        .ACC_W    (ACC_W)
      ) u_cell (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .in_valid_i  (valid_c[k]),
        .in_item_i   (item_c[k]),
        .in_acc_i    (acc_c[k]),
        .in_ready_o  (ready_c[k]),
        .out_valid_o (valid_c[k+1]),
        .out_item_o  (item_c[k+1]),
        .out_acc_o   (acc_c[k+1]),
        .out_ready_i (ready_c[k+1])
      );
    end
  endgenerate

  amm_out #(
    .NUM_OUT (NUM_OUT),
    .ACC_W   (ACC_W)
  ) u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (valid_c[NUM_IN]),
    .in_item_i    (item_c[NUM_IN]),
    .in_acc_i     (acc_c[NUM_IN]),
    .in_ready_o   (ready_c[NUM_IN]),
    .out_valid_o  (m_axis_tvalid),
    .out_sample_o (out_smp),
    .out_ready_i  (m_axis_tready)
  );

  assign m_axis_tdata = out_smp;

  // The input is never refused while the first cell is empty.
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_c[1] |-> s_axis_tready)
    else $error("input stalled with an empty first cell");

  // The output side never stalls a chain that is entirely idle.
  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!m_axis_tvalid && !valid_c[NUM_IN]) |-> ready_c[NUM_IN])
    else $error("idle output stage refused a word");

  // A result appears only after a frame left the last cell.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(valid_c[NUM_IN] &&
                                   item_c[NUM_IN].action == ACT_FRAME))
    else $error("result without a frame");

endmodule
`default_nettype wire

/* sim/audio_matrix_mixer_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Audio matrix mixer core testbench
// Sends gain writes and sample frames with random idle bursts on both stream
// sides. A local copy of the gain table predicts each frame word, and every
// output word is checked in order against that prediction.
// ----------------------------------------------------------------------------
module audio_matrix_mixer_core_test;
  import amm_pkg::*;

  localparam int NUM_IN       = 4;
  localparam int NUM_OUT      = 4;
  // Cycles to let pass after the last expected word, and the drain bound.
  localparam int DRAIN_CYCLES = NUM_IN + 16;
  localparam int DRAIN_LIMIT  = 20000;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // tdata: in_index, out_index, gain, in_sample_0..in_sample_3, zero fill
  logic [87:0] s_axis_tdata  = '0;
  // tuser: action
  logic [0:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // tdata: out_sample_0..out_sample_3
  logic [63:0] m_axis_tdata;

  // Local copy of the gain table, indexed by output row and input column.
  logic signed [GAIN_W-1:0] gain_q12 [NUM_OUT][NUM_IN];
  // Frame words predicted for accepted sample frames, oldest first.
  logic [63:0] frame_words_due [$];
  logic [63:0] due_word;
  int          error_count   = 0;
  bit          src_idle_on   = 1'b1;
  bit          sink_stall_on = 1'b1;
  int          sink_hold     = 0;

  always #5 clk_i = ~clk_i;

  audio_matrix_mixer_core #(
    .NUM_IN (NUM_IN),
    .NUM_OUT(NUM_OUT)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // Each output row is the exact sum of sample times gain, floored by the
  // fraction shift and clamped to the signed 16-bit range.
  function automatic logic [63:0] mix_frame(logic [FIELD_CH-1:0][SMP_W-1:0] smp);
    longint      acc;
    longint      y;
    logic [63:0] word;
    word = '0;
    for (int r = 0; r < NUM_OUT; r++) begin
      acc = 0;
      for (int c = 0; c < NUM_IN; c++) begin
        acc += longint'($signed(smp[c])) * longint'(gain_q12[r][c]);
      end
      y = acc >>> FRAC_SHIFT;
      if (y > SAT_MAX) begin
        y = SAT_MAX;
      end else if (y < SAT_MIN) begin
        y = SAT_MIN;
      end
      if (r < FIELD_CH) begin
        word[r*SMP_W +: SMP_W] = y[SMP_W-1:0];
      end
    end
    return word;
  endfunction

  // Random 16-bit value that favors the extremes; with narrow set, some draws
  // stay within plus or minus one in Q4.12 so that mixes do not always clip.
  function automatic logic [15:0] rand_level(bit narrow);
    case ($urandom_range(0, 7))
      0: return 16'h7fff;
      1: return 16'h8000;
      2, 3: return narrow ? 16'($urandom_range(0, 16'h2000) - 16'h1000) : 16'($urandom);
      default: return 16'($urandom);
    endcase
  endfunction

  // Offers one word on the input stream, waits for it to be taken and then
  // updates the prediction. Called at a rising edge, returns at one.
  task automatic send_word(action_e act, logic [IDX_W-1:0] col, logic [IDX_W-1:0] row,
                           logic [GAIN_W-1:0] gain, logic [FIELD_CH-1:0][SMP_W-1:0] smp);
    if (src_idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {4'b0, smp, gain, row, col};
    // Inputs only move at rising edges, so ready is stable at the falling one.
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
    if (act == ACT_GAIN) begin
      if (col < NUM_IN && row < NUM_OUT) begin
        gain_q12[row][col] = gain;
      end
    end else begin
      frame_words_due.push_back(mix_frame(smp));
    end
  endtask

  // The gain table starts at zero, so even full-scale samples mix to silence.
  task automatic test_zero_gains_after_reset();
    send_word(ACT_FRAME, 2'd3, 2'd3, 16'h7fff, {16'h0000, 16'hffff, 16'h8000, 16'h7fff});
  endtask

  // Unity gain on the diagonal passes each input to its own output. Sample
  // fields of a gain write and the gain field of the last frame carry noise.
  task automatic test_unity_diagonal();
    for (int k = 0; k < NUM_IN; k++) begin
      send_word(ACT_GAIN, IDX_W'(k), IDX_W'(k), 16'h1000, {$urandom, $urandom});
    end
    send_word(ACT_FRAME, 2'd0, 2'd0, 16'h0000, {16'hffff, 16'h0001, 16'h7fff, 16'h8000});
    send_word(ACT_FRAME, IDX_W'($urandom), IDX_W'($urandom), GAIN_W'($urandom),
              {$urandom, $urandom});
  endtask

  // Extreme gains against extreme samples clip in both directions.
  task automatic test_saturation();
    send_word(ACT_GAIN, 2'd0, 2'd0, 16'h7fff, {$urandom, $urandom});
    send_word(ACT_GAIN, 2'd1, 2'd1, 16'h8000, {$urandom, $urandom});
    send_word(ACT_GAIN, 2'd2, 2'd2, 16'h7fff, {$urandom, $urandom});
    send_word(ACT_GAIN, 2'd3, 2'd3, 16'h8000, {$urandom, $urandom});
    send_word(ACT_FRAME, IDX_W'($urandom), IDX_W'($urandom), GAIN_W'($urandom),
              {16'h8000, 16'h8000, 16'h7fff, 16'h7fff});
  endtask

  // The smallest gain shows that negative sums round toward minus infinity.
  task automatic test_floor_rounding();
    send_word(ACT_GAIN, 2'd0, 2'd0, 16'h0001, {$urandom, $urandom});
    send_word(ACT_FRAME, 2'd0, 2'd0, 16'h0000, {16'h0000, 16'h0000, 16'h0000, 16'hffff});
    send_word(ACT_FRAME, 2'd0, 2'd0, 16'h0000, {16'h0000, 16'h0000, 16'h0000, 16'h0001});
    send_word(ACT_FRAME, 2'd0, 2'd0, 16'h0000, {16'h0000, 16'h0000, 16'h0000, 16'h8000});
  endtask

  // Mixed traffic: about a quarter gain writes, the rest sample frames.
  task automatic test_random_traffic(int count);
    logic [FIELD_CH-1:0][SMP_W-1:0] smp;
    for (int n = 0; n < count; n++) begin
      for (int ch = 0; ch < FIELD_CH; ch++) begin
        smp[ch] = rand_level(1'b0);
      end
      if ($urandom_range(0, 3) == 0) begin
        send_word(ACT_GAIN, IDX_W'($urandom), IDX_W'($urandom), rand_level(1'b1), smp);
      end else begin
        send_word(ACT_FRAME, IDX_W'($urandom), IDX_W'($urandom), GAIN_W'($urandom), smp);
      end
    end
  endtask

  // Output side: ready drops in bursts of random length while enabled.
  always @(posedge clk_i) begin
    if (sink_hold != 0) begin
      sink_hold     <= sink_hold - 1;
      m_axis_tready <= (sink_hold == 1);
    end else if (rst_ni && sink_stall_on && $urandom_range(0, 4) == 0) begin
      m_axis_tready <= 1'b0;
      sink_hold     <= $urandom_range(1, 8);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Every word taken from the output stream must match the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (frame_words_due.size() == 0) begin
        $error("m_axis_tdata: expected no word, actual %h", m_axis_tdata);
        error_count++;
      end else begin
        due_word = frame_words_due.pop_front();
        for (int ch = 0; ch < FIELD_CH; ch++) begin
          if (m_axis_tdata[ch*SMP_W +: SMP_W] !== due_word[ch*SMP_W +: SMP_W]) begin
            $error("out_sample_%0d: expected %0d, actual %0d", ch,
                   $signed(due_word[ch*SMP_W +: SMP_W]),
                   $signed(m_axis_tdata[ch*SMP_W +: SMP_W]));
            error_count++;
          end
        end
      end
    end
  end

  initial begin
    int waited;
    waited = 0;
    for (int r = 0; r < NUM_OUT; r++) begin
      for (int c = 0; c < NUM_IN; c++) begin
        gain_q12[r][c] = '0;
      end
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_zero_gains_after_reset();
    test_unity_diagonal();
    test_saturation();
    test_floor_rounding();
    test_random_traffic(400);
    // The closing stretch runs at full rate on both sides.
    src_idle_on   = 1'b0;
    sink_stall_on = 1'b0;
    test_random_traffic(100);
    s_axis_tvalid <= 1'b0;

    while (frame_words_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (frame_words_due.size() != 0) begin
      $error("frame words: expected 0 outstanding, actual %0d", frame_words_due.size());
      error_count++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/amm_pkg.sv
hw/rtl/amm_cell.sv
hw/rtl/amm_out.sv
hw/rtl/audio_matrix_mixer_core.sv
sim/audio_matrix_mixer_core_test.sv
